// File: design/gts_pkg.sv
// shared widths, codes and state encoding for the gain tightening scheduler
`timescale 1ns / 1ps

package gts_pkg;

   // field widths
   localparam int GAIN_W      = 16;
   localparam int ANGLE_W     = 15;
   localparam int LEVEL_W     = 16;
   localparam int SPEED_W     = 24;
   localparam int CURRENT_W   = 16;
   localparam int ERROR_W     = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 3;

   // serial arithmetic: one operand bit per cycle
   localparam int OPND_W     = 16;
   localparam int PROD_W     = 2 * OPND_W;
   localparam int STEPS      = OPND_W;
   localparam int STEP_CNT_W = $clog2(STEPS);
   localparam int DIVISOR_W  = ANGLE_W;
   localparam int DIVIDEND_W = OPND_W + DIVISOR_W;
   localparam int NUM_LANES  = 4;

   // level of 1.0 in q0.16
   localparam logic [LEVEL_W-1:0] LEVEL_ONE       = '1;
   localparam logic [GAIN_W-1:0]  SMOOTHING_RESET = 16'd655;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACCEL_ANGLE = 3'd0,
      CSR_BRAKE_ANGLE = 3'd1,
      CSR_ACCEL_RAMP  = 3'd2,
      CSR_BRAKE_RAMP  = 3'd3,
      CSR_ACCEL_GAIN  = 3'd4,
      CSR_BRAKE_GAIN  = 3'd5,
      CSR_SMOOTHING   = 3'd6
   } csr_index_type;

   // sequencer states
   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_EMA    = 8'b0000_0010,
      ST_GO     = 8'b0000_0100,
      ST_BLEND  = 8'b0000_1000,
      ST_CHECK  = 8'b0001_0000,
      ST_SCALE  = 8'b0010_0000,
      ST_DIVIDE = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

endpackage

// File: design/gts_serial_mul.sv
// bit-serial shift-add unsigned multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module gts_serial_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gts_pkg::OPND_W-1:0]  multiplicand,
   input  logic [gts_pkg::OPND_W-1:0]  multiplier,
   output logic                        done,
   output logic [gts_pkg::PROD_W-1:0]  product
);
   import gts_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [OPND_W-1:0]     mcand_ff, mcand_in;
   logic [OPND_W-1:0]     hi_ff, hi_in;
   logic [OPND_W-1:0]     lo_ff, lo_in;
   logic [OPND_W:0]       sum;
   logic                  last;

   // one add and shift per cycle
   always_comb begin
      last     = (cnt_ff == STEP_CNT_W'(STEPS - 1));
      sum      = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, mcand_ff} : '0);
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = '0;
         mcand_in = multiplicand;
         hi_in    = '0;
         lo_in    = multiplier;
      end else if (busy_ff) begin
         hi_in   = sum[OPND_W:1];
         lo_in   = {sum[0], lo_ff[OPND_W-1:1]};
         cnt_in  = cnt_ff + STEP_CNT_W'(1);
         done_in = last;
         busy_in = !last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mcand_ff <= mcand_in;
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
   end

   assign done    = done_ff;
   assign product = {hi_ff, lo_ff};

endmodule

// File: design/gts_serial_div.sv
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module gts_serial_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [gts_pkg::DIVIDEND_W-1:0] dividend,
   input  logic [gts_pkg::DIVISOR_W-1:0]  divisor,
   output logic                           done,
   output logic [gts_pkg::OPND_W-1:0]     quotient
);
   import gts_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [OPND_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W+1:0]  diff;
   logic                  last;

   // shift in one dividend bit, subtract when it fits
   always_comb begin
      last    = (cnt_ff == STEP_CNT_W'(STEPS - 1));
      shifted = {rem_ff, quo_ff[OPND_W-1]};
      diff    = {1'b0, shifted} - {2'b00, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         // dividend is below divisor * 2^16, so the upper part is below the divisor
         busy_in = 1'b1;
         cnt_in  = '0;
         dsr_in  = divisor;
         rem_in  = dividend[DIVIDEND_W-1:OPND_W];
         quo_in  = dividend[OPND_W-1:0];
      end else if (busy_ff) begin
         if (!diff[DIVISOR_W+1]) begin
            rem_in = diff[DIVISOR_W-1:0];
            quo_in = {quo_ff[OPND_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_W-1:0];
            quo_in = {quo_ff[OPND_W-2:0], 1'b0};
         end
         cnt_in  = cnt_ff + STEP_CNT_W'(1);
         done_in = last;
         busy_in = !last;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      dsr_ff <= dsr_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: design/gain_tightening_scheduler.sv
// top level: sequencer, state levels, configuration registers and output register
`timescale 1ns / 1ps

// Pitch gain tightening scheduler. One beat on the req_ channel is one control
// tick; it yields exactly one beat on the rsp_ channel with a gain that never
// exceeds req_gain_in. Items are worked one at a time by four bit-serial
// multiplier lanes and one bit-serial divider. A tick that needs no ramp
// division takes two multiplier passes (level averaging, then blending) before
// it reaches the result register; a ramped gain takes two more passes (the span
// product and the divide). req_stall stays high until the sequencer is back
// in idle; a finished result waits in the output register, so the next tick is
// accepted while rsp_stall holds the previous one. csr_ready is always high;
// registers are to be written only while no tick is in flight, and the block
// itself does not enforce this. Unknown register indexes are ignored.
module gain_tightening_scheduler (
   input  logic                                clock,
   input  logic                                reset,
   // input beats
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_is_braking,
   input  logic                                req_is_forward,
   input  logic signed [gts_pkg::SPEED_W-1:0]  req_speed,
   input  logic signed [gts_pkg::CURRENT_W-1:0] req_motor_current,
   input  logic signed [gts_pkg::ERROR_W-1:0]  req_balance_error,
   input  logic [gts_pkg::GAIN_W-1:0]          req_gain_in,
   // result beats
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [gts_pkg::GAIN_W-1:0]          rsp_gain_out,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gts_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [gts_pkg::CSR_DATA_W-1:0]      csr_data
);
   import gts_pkg::*;

   // rounded q16 scaling of a product, half up on the magnitude
   function automatic logic [OPND_W-1:0] round_q16(input logic [PROD_W-1:0] p);
      logic [OPND_W:0] s;
      s = {1'b0, p[PROD_W-1:OPND_W]} + {{OPND_W{1'b0}}, p[OPND_W-1]};
      return s[OPND_W-1:0];
   endfunction

   // distance between two values
   function automatic logic [OPND_W-1:0] abs_diff(input logic [OPND_W-1:0] a,
                                                  input logic [OPND_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   // move a base value toward the far end by a scaled step
   function automatic logic [OPND_W-1:0] step_toward(input logic [OPND_W-1:0] base,
                                                     input logic             down,
                                                     input logic [OPND_W-1:0] q);
      return down ? (base - q) : (base + q);
   endfunction

   state_type state_ff, state_in;

   // configuration registers
   logic [ANGLE_W-1:0] accel_angle_ff, accel_angle_in;
   logic [ANGLE_W-1:0] brake_angle_ff, brake_angle_in;
   logic [ANGLE_W-1:0] accel_ramp_ff, accel_ramp_in;
   logic [ANGLE_W-1:0] brake_ramp_ff, brake_ramp_in;
   logic [GAIN_W-1:0]  accel_gain_ff, accel_gain_in;
   logic [GAIN_W-1:0]  brake_gain_ff, brake_gain_in;
   logic [GAIN_W-1:0]  smoothing_ff, smoothing_in;

   // averaged levels
   logic [LEVEL_W-1:0] braking_level_ff, braking_level_in;
   logic [LEVEL_W-1:0] direction_level_ff, direction_level_in;

   // latched tick and intermediate results
   logic               braking_ff, braking_in;
   logic               dir_tgt_ff, dir_tgt_in;
   logic [ERROR_W-1:0] err_ff, err_in;
   logic [GAIN_W-1:0]  gain_ff, gain_in;
   logic [OPND_W-1:0]  error_ff, error_in;
   logic [ANGLE_W-1:0] angle_ff, angle_in;
   logic [ANGLE_W-1:0] ramp_ff, ramp_in;
   logic [GAIN_W-1:0]  target_ff, target_in;
   logic [GAIN_W-1:0]  result_ff, result_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [GAIN_W-1:0]  rsp_gain_out_ff, rsp_gain_out_in;

   // multiplier lanes
   logic [NUM_LANES-1:0] lane_start;
   logic [NUM_LANES-1:0] lane_done;
   logic [OPND_W-1:0]    lane_a [NUM_LANES];
   logic [OPND_W-1:0]    lane_t [NUM_LANES];
   logic [PROD_W-1:0]    lane_prod [NUM_LANES];

   // divider
   logic                  div_start;
   logic                  div_done;
   logic [DIVIDEND_W-1:0] div_dividend;
   logic [OPND_W-1:0]     div_quotient;

   // combinational helpers
   logic               accept;
   logic               opposed;
   logic               tdir;
   logic [OPND_W-1:0]  err_mag;
   logic [OPND_W-1:0]  cm, bm;
   logic [OPND_W-1:0]  accel_angle_x, brake_angle_x, accel_ramp_x, brake_ramp_x;
   logic [GAIN_W-1:0]  at, bt;
   logic               angle_down, ramp_down, gain_down;
   logic [OPND_W-1:0]  q0, q1, q2, q3;
   logic [OPND_W-1:0]  angle_blend, ramp_blend;
   logic               tighten;
   logic [OPND_W-1:0]  excess;
   logic [GAIN_W-1:0]  span;
   logic               out_free;

   genvar g;
   generate
      for (g = 0; g < NUM_LANES; g++) begin : g_lane
         gts_serial_mul u_mul (
            .clock        (clock),
            .reset        (reset),
            .start        (lane_start[g]),
            .multiplicand (lane_a[g]),
            .multiplier   (lane_t[g]),
            .done         (lane_done[g]),
            .product      (lane_prod[g])
         );
      end
   endgenerate

   gts_serial_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (ramp_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // handshake
   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // direction target: torque direction when current opposes speed and not braking
   always_comb begin
      opposed = !req_is_braking && (req_speed != '0) && (req_motor_current != '0)
                && (req_speed[SPEED_W-1] != req_motor_current[CURRENT_W-1]);
      tdir    = opposed ? !req_motor_current[CURRENT_W-1] : req_is_forward;
   end

   // side weights and blend operands
   always_comb begin
      err_mag       = err_ff[ERROR_W-1] ? (~err_ff + 16'd1) : err_ff;
      cm            = ~abs_diff(direction_level_ff, ~braking_level_ff);
      bm            = ~abs_diff(direction_level_ff, braking_level_ff);
      accel_angle_x = {1'b0, accel_angle_ff};
      brake_angle_x = {1'b0, brake_angle_ff};
      accel_ramp_x  = {1'b0, accel_ramp_ff};
      brake_ramp_x  = {1'b0, brake_ramp_ff};
      at            = (accel_gain_ff != '0) ? accel_gain_ff : gain_ff;
      bt            = (brake_gain_ff != '0) ? brake_gain_ff : gain_ff;
      angle_down    = brake_angle_x < accel_angle_x;
      ramp_down     = brake_ramp_x < accel_ramp_x;
      gain_down     = bt < at;
      q0            = round_q16(lane_prod[0]);
      q1            = round_q16(lane_prod[1]);
      q2            = round_q16(lane_prod[2]);
      q3            = round_q16(lane_prod[3]);
      angle_blend   = step_toward(accel_angle_x, angle_down, q1);
      ramp_blend    = step_toward(accel_ramp_x, ramp_down, q2);
   end

   // tightening decision
   always_comb begin
      tighten = (target_ff != '0) && (gain_ff > target_ff) && (error_ff > {1'b0, angle_ff});
      excess  = error_ff - {1'b0, angle_ff};
      span    = gain_ff - target_ff;
   end

   // lane operands by phase
   always_comb begin
      lane_start = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane_a[i] = '0;
         lane_t[i] = '0;
      end
      case (state_ff)
         ST_IDLE: begin
            // distance of each level to its target, scaled by alpha
            lane_a[0]     = req_is_braking ? ~braking_level_ff : braking_level_ff;
            lane_t[0]     = smoothing_ff;
            lane_a[1]     = tdir ? ~direction_level_ff : direction_level_ff;
            lane_t[1]     = smoothing_ff;
            lane_start[0] = accept;
            lane_start[1] = accept;
         end
         ST_GO: begin
            lane_a[0]  = err_mag;
            lane_t[0]  = err_ff[ERROR_W-1] ? bm : cm;
            lane_a[1]  = abs_diff(accel_angle_x, brake_angle_x);
            lane_t[1]  = braking_level_ff;
            lane_a[2]  = abs_diff(accel_ramp_x, brake_ramp_x);
            lane_t[2]  = braking_level_ff;
            lane_a[3]  = abs_diff(at, bt);
            lane_t[3]  = braking_level_ff;
            lane_start = '1;
         end
         ST_CHECK: begin
            lane_a[0]     = span;
            lane_t[0]     = excess;
            lane_start[0] = tighten && (excess < {1'b0, ramp_ff});
         end
         default: begin
         end
      endcase
   end

   // rounding offset of half the ramp, then divide
   assign div_start    = (state_ff == ST_SCALE) && lane_done[0];
   assign div_dividend = lane_prod[0][DIVIDEND_W-1:0]
                         + {{(DIVIDEND_W-ANGLE_W+1){1'b0}}, ramp_ff[ANGLE_W-1:1]};

   // sequencer and datapath next values
   always_comb begin
      state_in           = state_ff;
      braking_level_in   = braking_level_ff;
      direction_level_in = direction_level_ff;
      braking_in         = braking_ff;
      dir_tgt_in         = dir_tgt_ff;
      err_in             = err_ff;
      gain_in            = gain_ff;
      error_in           = error_ff;
      angle_in           = angle_ff;
      ramp_in            = ramp_ff;
      target_in          = target_ff;
      result_in          = result_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_gain_out_in    = rsp_gain_out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               braking_in = req_is_braking;
               dir_tgt_in = tdir;
               err_in     = req_balance_error;
               gain_in    = req_gain_in;
               state_in   = ST_EMA;
            end
         end
         ST_EMA: begin
            if (lane_done[0]) begin
               braking_level_in   = step_toward(braking_level_ff, !braking_ff, q0);
               direction_level_in = step_toward(direction_level_ff, !dir_tgt_ff, q1);
               state_in           = ST_GO;
            end
         end
         ST_GO: begin
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            if (lane_done[0]) begin
               error_in  = q0;
               angle_in  = angle_blend[ANGLE_W-1:0];
               ramp_in   = ramp_blend[ANGLE_W-1:0];
               target_in = step_toward(at, gain_down, q3);
               state_in  = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!tighten) begin
               result_in = gain_ff;
               state_in  = ST_FINISH;
            end else if (excess >= {1'b0, ramp_ff}) begin
               result_in = target_ff;
               state_in  = ST_FINISH;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (lane_done[0]) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               result_in = gain_ff - div_quotient;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in    = 1'b1;
               rsp_gain_out_in = result_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // register writes
   always_comb begin
      accel_angle_in = accel_angle_ff;
      brake_angle_in = brake_angle_ff;
      accel_ramp_in  = accel_ramp_ff;
      brake_ramp_in  = brake_ramp_ff;
      accel_gain_in  = accel_gain_ff;
      brake_gain_in  = brake_gain_ff;
      smoothing_in   = smoothing_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_ANGLE: accel_angle_in = csr_data[ANGLE_W-1:0];
            CSR_BRAKE_ANGLE: brake_angle_in = csr_data[ANGLE_W-1:0];
            CSR_ACCEL_RAMP:  accel_ramp_in  = csr_data[ANGLE_W-1:0];
            CSR_BRAKE_RAMP:  brake_ramp_in  = csr_data[ANGLE_W-1:0];
            CSR_ACCEL_GAIN:  accel_gain_in  = csr_data[GAIN_W-1:0];
            CSR_BRAKE_GAIN:  brake_gain_in  = csr_data[GAIN_W-1:0];
            CSR_SMOOTHING:   smoothing_in   = csr_data[GAIN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // control, configuration and level state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         rsp_valid_ff       <= 1'b0;
         braking_level_ff   <= '0;
         direction_level_ff <= LEVEL_ONE;
         accel_angle_ff     <= '0;
         brake_angle_ff     <= '0;
         accel_ramp_ff      <= '0;
         brake_ramp_ff      <= '0;
         accel_gain_ff      <= '0;
         brake_gain_ff      <= '0;
         smoothing_ff       <= SMOOTHING_RESET;
      end else begin
         state_ff           <= state_in;
         rsp_valid_ff       <= rsp_valid_in;
         braking_level_ff   <= braking_level_in;
         direction_level_ff <= direction_level_in;
         accel_angle_ff     <= accel_angle_in;
         brake_angle_ff     <= brake_angle_in;
         accel_ramp_ff      <= accel_ramp_in;
         brake_ramp_ff      <= brake_ramp_in;
         accel_gain_ff      <= accel_gain_in;
         brake_gain_ff      <= brake_gain_in;
         smoothing_ff       <= smoothing_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      braking_ff      <= braking_in;
      dir_tgt_ff      <= dir_tgt_in;
      err_ff          <= err_in;
      gain_ff         <= gain_in;
      error_ff        <= error_in;
      angle_ff        <= angle_in;
      ramp_ff         <= ramp_in;
      target_ff       <= target_in;
      result_ff       <= result_in;
      rsp_gain_out_ff <= rsp_gain_out_in;
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gain_out = rsp_gain_out_ff;
   assign csr_ready    = 1'b1;

`ifndef SYNTHESIS
   // the result never exceeds the gain of its tick
   a_gain_not_raised: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (result_ff <= gain_ff))
      else $error("scheduled gain above input gain");

   // the divider is only started with a nonzero ramp
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (ramp_ff != '0))
      else $error("divide started with zero ramp");

   // the divider finishes only while the sequencer waits for it
   a_div_phase: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside its phase");

   // lane zero finishes only in a phase that waits on it
   a_lane_phase: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (state_ff == ST_EMA || state_ff == ST_BLEND || state_ff == ST_SCALE))
      else $error("multiplier lane finished outside its phase");
`endif

endmodule
